@@ design/bdlr_pkg.sv @@
// Shared types, constants and helpers of the button debounce, long-press and repeat unit.
`timescale 1ns / 1ps

package bdlr_pkg;

  // Default geometry
  localparam int BDLR_BUTTONS   = 6;
  localparam int BDLR_TIME_BITS = 32;

  // Fixed field widths of the beats
  localparam int IDX_W      = 3;
  localparam int TIME_W     = 32;
  localparam int MCNT_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Depth of the result queue: room for two stage beats of two events
  localparam int EVQ_DEPTH = 4;

  // Register values after reset
  localparam logic              POL_RST = 1'b0;
  localparam logic [MCNT_W-1:0] DBC_RST = 4'd4;
  localparam logic [15:0]       LPT_RST = 16'd800;
  localparam logic [15:0]       RDL_RST = 16'd400;
  localparam logic [15:0]       RPP_RST = 16'd120;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLARITY      = 3'd0,
    CFG_DEBOUNCE      = 3'd1,
    CFG_HOLD_TIME     = 3'd2,
    CFG_REPEAT_DELAY  = 3'd3,
    CFG_REPEAT_PERIOD = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_SEED   = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_LONG    = 2'd2,
    EV_REPEAT  = 2'd3
  } ev_kind_t;

  typedef struct packed {
    action_t             action;
    logic [IDX_W-1:0]    button_index;
    logic                raw_level;
    logic                force_pressed;
    logic [TIME_W-1:0]   time_ms;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]    event_button;
    ev_kind_t            event_kind;
    logic [TIME_W-1:0]   event_time;
    logic                held_now;
    logic                last_of_run;
  } out_beat_t;

  // A register written as zero counts as one
  function automatic logic [MCNT_W-1:0] nonzero4(input logic [MCNT_W-1:0] v);
    return (v == '0) ? MCNT_W'(1) : v;
  endfunction

  function automatic logic [15:0] nonzero16(input logic [15:0] v);
    return (v == '0) ? 16'd1 : v;
  endfunction

endpackage

@@ design/button_debounce_longpress_repeat_unit.sv @@
// Top level: per-button debounce, press/release, long-press and auto-repeat events.
//
//  port group  direction  beat / handshake
//  in_*        sink       in_beat_t  (in_valid, in_stall)    one button sample
//  out_*       source     out_beat_t (out_valid, out_stall)  one button event
//  cfg_*       sink       cfg_we, cfg_index, cfg_data        register write
//
// A sample is accepted in any cycle in which in_stall is low; its state entry is read
// from the state RAM (registered read), updated and written back as it leaves stage
// one, and its events land in a four-deep queue. The queue drains one event a cycle
// while out_stall is low; a sample raises at most two events, and a same-button sample
// right behind takes the entry through forwarding.
// Reset is synchronous; per-entry valid bits make unwritten buttons read as released.
// in_stall rises while stage one is full and the queue cannot take two more events.
`timescale 1ns / 1ps

module button_debounce_longpress_repeat_unit
  import bdlr_pkg::*;
#(
  parameter int BUTTONS   = BDLR_BUTTONS,
  parameter int TIME_BITS = BDLR_TIME_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW    = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam int QAW   = $clog2(EVQ_DEPTH);
  localparam int QCW   = $clog2(EVQ_DEPTH + 1);
  localparam int TB    = TIME_BITS;

  typedef struct packed {
    logic              acc;
    logic              cand;
    logic [MCNT_W-1:0] mc;
    logic              ld;
    logic [TB-1:0]     pt;
    logic [TB-1:0]     rd;
  } entry_t;

  localparam int EW = $bits(entry_t);

  // Configuration registers
  logic              pol_r;
  logic [MCNT_W-1:0] dbc_r;
  logic [15:0]       lpt_r;
  logic [15:0]       rdl_r;
  logic [15:0]       rpp_r;

  // Stage one and forwarding
  logic      s1_valid_r, s1_valid_nxt;
  in_beat_t  s1_beat_r;
  logic      fwd_hit_r;
  entry_t    fwd_data_r;
  logic      s1_go;
  logic      s1_push;
  logic      s1_in_range;
  logic [AW-1:0] s1_addr, in_addr;
  logic      in_accept;

  // State store
  logic [BUTTONS-1:0] valid_r;
  logic               ram_we;
  logic [EW-1:0]      ram_rdata;
  entry_t             cur, nxt;

  // Update datapath
  logic [TB-1:0]     t;
  logic              level, pressed, sample, press_now, ev_acc, fire_long, fire_rep;
  ev_kind_t          ev_acc_kind;
  logic [MCNT_W:0]   cnt_inc;
  logic [MCNT_W-1:0] dbc_eff;
  logic [15:0]       lpt_eff, rdl_eff, rpp_eff;
  logic [TB-1:0]     due_press, neg_rdl, d_long, d_rep;
  logic              rep_ok;
  logic [1:0]        n_ev;
  out_beat_t         beat0, beat1;

  // Result queue
  out_beat_t          q_r [EVQ_DEPTH];
  logic [QAW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCW-1:0]     cnt_r, cnt_nxt;
  logic               pop;
  logic [1:0]         push_n;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_r <= POL_RST;
      dbc_r <= DBC_RST;
      lpt_r <= LPT_RST;
      rdl_r <= RDL_RST;
      rpp_r <= RPP_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_POLARITY:      pol_r <= cfg_data[0];
        CFG_DEBOUNCE:      dbc_r <= cfg_data[MCNT_W-1:0];
        CFG_HOLD_TIME:     lpt_r <= cfg_data;
        CFG_REPEAT_DELAY:  rdl_r <= cfg_data;
        CFG_REPEAT_PERIOD: rpp_r <= cfg_data;
        default:           ;
      endcase
    end
  end

  assign dbc_eff = nonzero4(dbc_r);
  assign lpt_eff = nonzero16(lpt_r);
  assign rdl_eff = nonzero16(rdl_r);
  assign rpp_eff = nonzero16(rpp_r);

  // Handshake of stage one
  assign in_accept   = in_valid && !in_stall;
  assign pop         = out_valid && !out_stall;
  assign s1_go       = (cnt_r <= QCW'(EVQ_DEPTH - 2)) || (cnt_r == QCW'(EVQ_DEPTH - 1) && pop);
  assign in_stall    = s1_valid_r && !s1_go;
  assign s1_push     = s1_valid_r && s1_go;
  assign in_addr     = AW'(in_data.button_index);
  assign s1_addr     = AW'(s1_beat_r.button_index);
  assign s1_in_range = 32'(s1_beat_r.button_index) < BUTTONS;
  assign ram_we      = s1_push && s1_in_range;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
      valid_r    <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (in_accept) begin
        fwd_hit_r <= ram_we && (s1_addr == in_addr);
      end
      if (ram_we) begin
        valid_r[s1_addr] <= 1'b1;
      end
    end
  end

  // Capture the sample and the entry being written beside its read
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_beat_r  <= in_data;
      fwd_data_r <= nxt;
    end
  end

  bdlr_ram #(
    .WIDTH (EW),
    .DEPTH (BUTTONS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (nxt),
    .re    (in_accept),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // Pick the freshest copy of the entry; unwritten buttons read as released
  always_comb begin
    if (fwd_hit_r) begin
      cur = fwd_data_r;
    end else if (valid_r[s1_addr]) begin
      cur = entry_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  assign t         = s1_beat_r.time_ms[TB-1:0];
  assign level     = (s1_beat_r.raw_level == pol_r);
  assign pressed   = level | s1_beat_r.force_pressed;
  assign sample    = (s1_beat_r.action == ACT_SAMPLE) && s1_in_range;
  assign cnt_inc   = {1'b0, cur.mc} + (MCNT_W + 1)'(1);
  assign due_press = t + TB'(rdl_eff);
  assign neg_rdl   = TB'(0) - TB'(rdl_eff);
  assign d_long    = t - cur.pt;
  assign d_rep     = t - cur.rd;

  // Seeding, debounce and level acceptance
  always_comb begin
    nxt         = cur;
    ev_acc      = 1'b0;
    ev_acc_kind = EV_PRESS;
    press_now   = 1'b0;
    if (s1_beat_r.action == ACT_SEED) begin
      nxt.acc  = level;
      nxt.cand = level;
      nxt.mc   = '0;
      nxt.ld   = 1'b0;
      nxt.pt   = t;
      nxt.rd   = due_press;
    end else if (pressed != cur.acc) begin
      if (pressed == cur.cand) begin
        if (cnt_inc >= {1'b0, dbc_eff}) begin
          nxt.acc = pressed;
          nxt.mc  = '0;
          ev_acc  = 1'b1;
          if (pressed) begin
            nxt.ld      = 1'b0;
            nxt.pt      = t;
            nxt.rd      = due_press;
            ev_acc_kind = EV_PRESS;
            press_now   = 1'b1;
          end else begin
            ev_acc_kind = EV_RELEASE;
          end
        end else begin
          nxt.mc = cnt_inc[MCNT_W-1:0];
        end
      end else begin
        nxt.cand = pressed;
        nxt.mc   = MCNT_W'(1);
      end
    end else begin
      nxt.cand = pressed;
      nxt.mc   = '0;
    end
    // Long press and repeat while held; a fresh press cannot reach the long limit
    fire_long = sample && nxt.acc && !press_now && !cur.ld
                && !d_long[TB-1] && (d_long >= TB'(lpt_eff));
    rep_ok    = press_now ? !neg_rdl[TB-1] : !d_rep[TB-1];
    fire_rep  = sample && nxt.acc && !(ev_acc && fire_long) && rep_ok;
    if (fire_long) begin
      nxt.ld = 1'b1;
    end
    if (fire_rep) begin
      nxt.rd = t + TB'(rpp_eff);
    end
  end

  // Assemble up to two event beats
  always_comb begin
    n_ev = 2'd0;
    if (sample) begin
      n_ev = 2'(ev_acc) + 2'(fire_long) + 2'(fire_rep);
    end
    beat0.event_button = s1_beat_r.button_index;
    beat0.event_time   = TIME_W'(t);
    beat0.held_now     = nxt.acc;
    beat0.last_of_run  = (n_ev == 2'd1);
    if (ev_acc) begin
      beat0.event_kind = ev_acc_kind;
    end else if (fire_long) begin
      beat0.event_kind = EV_LONG;
    end else begin
      beat0.event_kind = EV_REPEAT;
    end
    beat1             = beat0;
    beat1.last_of_run = 1'b1;
    beat1.event_kind  = fire_rep ? EV_REPEAT : EV_LONG;
  end

  // Result queue pointers
  assign push_n = s1_push ? n_ev : 2'd0;

  always_comb begin
    wp_nxt  = wp_r + QAW'(push_n);
    rp_nxt  = rp_r + QAW'(pop);
    cnt_nxt = cnt_r + QCW'(push_n) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wp_r] <= beat0;
    end
    if (push_n == 2'd2) begin
      q_r[wp_r + QAW'(1)] <= beat1;
    end
  end

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rp_r];

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(EVQ_DEPTH))
    else $error("result queue overfilled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && cnt_r >= QCW'(EVQ_DEPTH - 1)))
    else $error("input stalled without a full queue");

  a_forward: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && ram_we && s1_addr == in_addr) |=> fwd_hit_r)
    else $error("write-back to the entry just read not forwarded");

  a_release_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.event_kind == EV_RELEASE) |-> !out_data.held_now)
    else $error("release event with button still held");

  a_other_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.event_kind != EV_RELEASE) |-> out_data.held_now)
    else $error("press, long or repeat event with button released");
`endif

endmodule

@@ design/bdlr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bdlr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
